FILE: sv/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with asynchronous reset disable
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: sv/ddshp_pkg.sv
`timescale 1ns / 1ps
package ddshp_pkg;

  localparam logic [31:0] MagicWord   = 32'h2053_4444;
  localparam logic [31:0] HeaderBytes = 32'd124;
  localparam logic [31:0] PformBytes  = 32'd32;
  localparam logic [31:0] ReqFlags    = 32'h0000_1007;
  localparam logic [31:0] FlagMipCnt  = 32'h0002_0000;
  localparam logic [31:0] FlagDepth   = 32'h0080_0000;
  localparam logic [31:0] Caps2Cube   = 32'h0000_0200;
  localparam logic [31:0] PfFourcc    = 32'h0000_0004;
  localparam logic [31:0] PfRgb       = 32'h0000_0040;
  localparam logic [31:0] CcDxt1      = 32'h3154_5844;
  localparam logic [31:0] CcDxt2      = 32'h3254_5844;
  localparam logic [31:0] CcDxt3      = 32'h3354_5844;
  localparam logic [31:0] CcDxt4      = 32'h3454_5844;
  localparam logic [31:0] CcDxt5      = 32'h3554_5844;
  localparam logic [31:0] CcDx10      = 32'h3031_5844;

  localparam logic [3:0] StOk      = 4'd0;
  localparam logic [3:0] StMagic   = 4'd1;
  localparam logic [3:0] StSize    = 4'd2;
  localparam logic [3:0] StFlags   = 4'd3;
  localparam logic [3:0] StPfSize  = 4'd4;
  localparam logic [3:0] StDx10    = 4'd5;
  localparam logic [3:0] StCube    = 4'd6;
  localparam logic [3:0] StFormat  = 4'd7;
  localparam logic [3:0] StZeroDim = 4'd8;
  localparam logic [3:0] StMips    = 4'd9;
  localparam logic [3:0] StLarge   = 4'd10;

  localparam logic [2:0] FmtRgb24  = 3'd0;
  localparam logic [2:0] FmtBgr24  = 3'd1;
  localparam logic [2:0] FmtRgba32 = 3'd2;
  localparam logic [2:0] FmtBgra32 = 3'd3;
  localparam logic [2:0] FmtBc1    = 3'd4;
  localparam logic [2:0] FmtBc2    = 3'd5;
  localparam logic [2:0] FmtBc3    = 3'd6;

  localparam logic [4:0] WiMagic = 5'd0;
  localparam logic [4:0] WiSize  = 5'd1;
  localparam logic [4:0] WiFlags = 5'd2;
  localparam logic [4:0] WiHgt   = 5'd3;
  localparam logic [4:0] WiWid   = 5'd4;
  localparam logic [4:0] WiDep   = 5'd6;
  localparam logic [4:0] WiMips  = 5'd7;
  localparam logic [4:0] WiPfSz  = 5'd19;
  localparam logic [4:0] WiPfFl  = 5'd20;
  localparam logic [4:0] WiCc    = 5'd21;
  localparam logic [4:0] WiBits  = 5'd22;
  localparam logic [4:0] WiMaskR = 5'd23;
  localparam logic [4:0] WiMaskG = 5'd24;
  localparam logic [4:0] WiMaskB = 5'd25;
  localparam logic [4:0] WiMaskA = 5'd26;
  localparam logic [4:0] WiCaps2 = 5'd28;
  localparam logic [4:0] WiLast  = 5'd31;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // store header_word at its index
    logic magic_err;
    logic start;    // load level 0 from captured header
    logic step;     // compute products for current level
    logic advance;  // move to next level
  } ddshp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       word_last;
    logic       magic_ok;
    logic [3:0] status;
    logic       level_last;
  } ddshp_sts_t;

endpackage

FILE: sv/ddshp_datapath.sv
`timescale 1ns / 1ps
module ddshp_datapath import ddshp_pkg::*; #(
  parameter int MAX_MIPS = 16,
  parameter int MAX_DIM  = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ddshp_cmd_t  cmd_i,
  output ddshp_sts_t  sts_o,
  input  logic [31:0] header_word_i,
  output logic [3:0]  status_o,
  output logic [2:0]  format_o,
  output logic        is_volume_o,
  output logic [3:0]  level_idx_o,
  output logic [14:0] lvl_width_o,
  output logic [14:0] lvl_height_o,
  output logic [14:0] lvl_depth_o,
  output logic [16:0] row_stride_o,
  output logic [30:0] slice_stride_o,
  output logic [47:0] byte_offset_o,
  output logic [47:0] byte_count_o,
  output logic        last_o
);

  logic [4:0]  widx_q;
  logic [31:0] hsize_q, hflags_q, hgt_q, wid_q, dep_q, mipc_q;
  logic [31:0] pfsz_q, pffl_q, cc_q, bits_q, caps2_q;
  logic [31:0] mask_q [4];

  // word 31 is not stored; the index wraps to 0 on it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q <= '0;
      hsize_q <= '0; hflags_q <= '0; hgt_q <= '0; wid_q <= '0; dep_q <= '0;
      mipc_q <= '0; pfsz_q <= '0; pffl_q <= '0; cc_q <= '0; bits_q <= '0;
      caps2_q <= '0;
      for (int i = 0; i < 4; i++) mask_q[i] <= '0;
    end else if (cmd_i.capture) begin
      widx_q <= widx_q + 5'd1;
      unique case (widx_q)
        WiSize:  hsize_q  <= header_word_i;
        WiFlags: hflags_q <= header_word_i;
        WiHgt:   hgt_q    <= header_word_i;
        WiWid:   wid_q    <= header_word_i;
        WiDep:   dep_q    <= header_word_i;
        WiMips:  mipc_q   <= header_word_i;
        WiPfSz:  pfsz_q   <= header_word_i;
        WiPfFl:  pffl_q   <= header_word_i;
        WiCc:    cc_q     <= header_word_i;
        WiBits:  bits_q   <= header_word_i;
        WiMaskR: mask_q[0] <= header_word_i;
        WiMaskG: mask_q[1] <= header_word_i;
        WiMaskB: mask_q[2] <= header_word_i;
        WiMaskA: mask_q[3] <= header_word_i;
        WiCaps2: caps2_q  <= header_word_i;
        default: ;
      endcase
    end
  end

  // header checks (word 31 itself is not stored)
  logic        vol;
  logic [31:0] deff, meff;
  logic        rgba, bgra, fmt_ok;
  logic [2:0]  fmt;
  logic [3:0]  chk;

  always_comb begin
    vol  = (hflags_q & FlagDepth) != '0;
    deff = (vol && dep_q != '0) ? dep_q : 32'd1;
    meff = ((hflags_q & FlagMipCnt) != '0 && mipc_q != '0) ? mipc_q : 32'd1;
    rgba = mask_q[0] == 32'h0000_00ff && mask_q[1] == 32'h0000_ff00
        && mask_q[2] == 32'h00ff_0000;
    bgra = mask_q[0] == 32'h00ff_0000 && mask_q[1] == 32'h0000_ff00
        && mask_q[2] == 32'h0000_00ff;
    fmt_ok = 1'b0;
    fmt    = FmtRgb24;
    if ((pffl_q & PfRgb) != '0) begin
      if (bits_q == 32'd24 && mask_q[3] == '0 && (rgba || bgra)) begin
        fmt_ok = 1'b1; fmt = rgba ? FmtRgb24 : FmtBgr24;
      end else if (bits_q == 32'd32 && mask_q[3] == 32'hff00_0000 && (rgba || bgra)) begin
        fmt_ok = 1'b1; fmt = rgba ? FmtRgba32 : FmtBgra32;
      end
    end else if ((pffl_q & PfFourcc) != '0) begin
      if (cc_q == CcDxt1) begin
        fmt_ok = 1'b1; fmt = FmtBc1;
      end else if (cc_q == CcDxt2 || cc_q == CcDxt3) begin
        fmt_ok = 1'b1; fmt = FmtBc2;
      end else if (cc_q == CcDxt4 || cc_q == CcDxt5) begin
        fmt_ok = 1'b1; fmt = FmtBc3;
      end
    end
    priority if (hsize_q != HeaderBytes)                         chk = StSize;
    else if ((hflags_q & ReqFlags) != ReqFlags)                  chk = StFlags;
    else if (pfsz_q != PformBytes)                               chk = StPfSize;
    else if ((pffl_q & PfFourcc) != '0 && cc_q == CcDx10)        chk = StDx10;
    else if ((caps2_q & Caps2Cube) != '0)                        chk = StCube;
    else if (!fmt_ok)                                            chk = StFormat;
    else if (wid_q == '0 || hgt_q == '0)                         chk = StZeroDim;
    else if (meff > 32'(MAX_MIPS))                               chk = StMips;
    else if (wid_q > 32'(MAX_DIM) || hgt_q > 32'(MAX_DIM) || deff > 32'(MAX_DIM))
                                                                 chk = StLarge;
    else                                                         chk = StOk;
  end

  // per-level state
  logic [16:0] w_q, h_q, d_q;
  logic [5:0]  nmip_q;
  logic [4:0]  lvl_q;
  logic [2:0]  fmt_q;
  logic        vol_q;
  logic [47:0] off_q;
  logic [16:0] row;
  logic [14:0] rows;

  always_comb begin
    if (fmt_q == FmtBc1)      row = 17'((w_q + 17'd3) >> 2) << 3;
    else if (fmt_q >= FmtBc2) row = 17'((w_q + 17'd3) >> 2) << 4;
    else                      row = 17'(w_q << 2);
    rows = (fmt_q >= FmtBc1) ? 15'((h_q + 17'd3) >> 2) : h_q[14:0];
  end

  logic [30:0] slice_q;
  logic [16:0] row_q;
  logic [47:0] size;

  assign size = 48'(slice_q) * 48'(d_q[14:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      w_q    <= wid_q[16:0];
      h_q    <= hgt_q[16:0];
      d_q    <= deff[16:0];
      nmip_q <= meff[5:0];
      lvl_q  <= '0;
      fmt_q  <= fmt;
      vol_q  <= vol;
      off_q  <= '0;
    end else if (cmd_i.advance) begin
      off_q <= off_q + size;
      lvl_q <= lvl_q + 5'd1;
      w_q   <= (w_q > 17'd1) ? (w_q >> 1) : 17'd1;
      h_q   <= (h_q > 17'd1) ? (h_q >> 1) : 17'd1;
      d_q   <= (d_q > 17'd1) ? (d_q >> 1) : 17'd1;
    end
    if (cmd_i.step) begin
      row_q   <= row;
      slice_q <= 31'(32'(row) * 32'(rows));
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.magic_err || (cmd_i.start && chk != StOk)) begin
      status_o <= cmd_i.magic_err ? StMagic : chk;
      format_o <= '0; is_volume_o <= 1'b0; level_idx_o <= '0;
      lvl_width_o <= '0; lvl_height_o <= '0; lvl_depth_o <= '0;
      row_stride_o <= '0; slice_stride_o <= '0; byte_offset_o <= '0;
      byte_count_o <= '0; last_o <= 1'b1;
    end else if (cmd_i.advance) begin
      status_o <= StOk; format_o <= fmt_q; is_volume_o <= vol_q;
      level_idx_o <= lvl_q[3:0];
      lvl_width_o <= w_q[14:0]; lvl_height_o <= h_q[14:0];
      lvl_depth_o <= d_q[14:0];
      row_stride_o <= row_q; slice_stride_o <= slice_q;
      byte_offset_o <= off_q; byte_count_o <= size;
      last_o <= (6'(lvl_q) + 6'd1 == nmip_q);
    end
  end

  assign sts_o.word_last  = widx_q == WiLast;
  assign sts_o.magic_ok   = widx_q != WiMagic || header_word_i == MagicWord;
  assign sts_o.status     = chk;
  assign sts_o.level_last = 6'(lvl_q) + 6'd1 == nmip_q;

endmodule

FILE: sv/ddshp_ctrl.sv
`timescale 1ns / 1ps
module ddshp_ctrl import ddshp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  ddshp_sts_t sts_i,
  output ddshp_cmd_t cmd_o
);

  typedef enum logic [1:0] {SIdle, SStep, SEmit} state_e;
  state_e state_q;
  logic   ovalid_q;
  logic   oslot_free, acc;

  assign oslot_free  = !ovalid_q || !out_stall_i;
  assign in_stall_o  = (state_q != SIdle) || !oslot_free;
  assign acc         = in_valid_i && !in_stall_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.capture   = acc && sts_i.magic_ok;
    cmd_o.magic_err = acc && !sts_i.magic_ok;
    cmd_o.start     = acc && sts_i.word_last;
    cmd_o.step      = state_q == SStep;
    cmd_o.advance   = state_q == SEmit && oslot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      ovalid_q <= 1'b0;
    end else begin
      ovalid_q <= cmd_o.magic_err || (cmd_o.start && sts_i.status != StOk)
               || cmd_o.advance || (ovalid_q && out_stall_i);
      unique case (state_q)
        SIdle: begin
          if (cmd_o.start && sts_i.status == StOk) state_q <= SStep;
        end
        SStep: state_q <= SEmit;
        SEmit: begin
          if (cmd_o.advance) state_q <= sts_i.level_last ? SIdle : SStep;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule

FILE: sv/dds_header_parse_mip_layout_core.sv
`timescale 1ns / 1ps
// Texture-file header parser. Takes one 32-bit header word per cycle while in_stall_o is
// low (word index held internally). A bad magic word gives a single error transfer.
// Word 31 triggers the checks; a failed check gives a single error result, otherwise one
// result per mip level follows, each level computed in two steps (stride/slice product,
// then size product and offset accumulation). Input is stalled while the levels are
// produced.
module dds_header_parse_mip_layout_core import ddshp_pkg::*; #(
  parameter int MAX_MIPS = 16,
  parameter int MAX_DIM  = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] header_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_o,
  output logic [2:0]  format_o,
  output logic        is_volume_o,
  output logic [3:0]  level_idx_o,
  output logic [14:0] lvl_width_o,
  output logic [14:0] lvl_height_o,
  output logic [14:0] lvl_depth_o,
  output logic [16:0] row_stride_o,
  output logic [30:0] slice_stride_o,
  output logic [47:0] byte_offset_o,
  output logic [47:0] byte_count_o,
  output logic        last_o
);

  ddshp_cmd_t cmd;
  ddshp_sts_t sts;

  ddshp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ddshp_datapath #(.MAX_MIPS(MAX_MIPS), .MAX_DIM(MAX_DIM)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .header_word_i,
    .status_o, .format_o, .is_volume_o, .level_idx_o, .lvl_width_o,
    .lvl_height_o, .lvl_depth_o, .row_stride_o, .slice_stride_o,
    .byte_offset_o, .byte_count_o, .last_o
  );

endmodule

FILE: sv/ddshp_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ddshp_checker import ddshp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [3:0] status_o,
  input logic       last_o
);
  `ASSERT_IMPL(a_err_last, clk_i, rst_ni, out_valid_o && status_o != StOk, last_o)
  `ASSERT_IMPL(a_status_rng, clk_i, rst_ni, out_valid_o, status_o <= StLarge)
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o))
  `ASSERT_IMPL(a_mid_stall, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_o, in_stall_o)
endmodule

bind dds_header_parse_mip_layout_core ddshp_checker u_chk (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .last_o
);
